// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clk edge, off while rst is high.
`define SBCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication form of the check above.
`define SBCM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/sbcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcm_pkg
// Types, widths, request codes and saturation helpers of the swept box mover.
// ----------------------------------------------------------------------------
package sbcm_pkg;

  localparam int MAX_STATIC = 64;
  localparam int IDX_W      = (MAX_STATIC > 1) ? $clog2(MAX_STATIC) : 1;
  localparam int CNT_W      = $clog2(MAX_STATIC + 1);

  localparam int KIND_W = 2;
  localparam int POS_W  = 16;
  localparam int SIZE_W = 12;
  localparam int VEL_W  = 11;
  localparam int NVEL_W = 14;
  // Positions and movements while sweeping stay well inside this width.
  localparam int CALC_W = 20;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ACTOR  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PROJ   = 2'd3;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_STATIC);

  localparam logic signed [CALC_W-1:0] POS_HI  = CALC_W'(2 ** (POS_W - 1) - 1);
  localparam logic signed [CALC_W-1:0] POS_LO  = -POS_HI - CALC_W'(1);
  localparam logic signed [CALC_W-1:0] NVEL_HI = CALC_W'(2 ** (NVEL_W - 1) - 1);
  localparam logic signed [CALC_W-1:0] NVEL_LO = -NVEL_HI;

  typedef struct packed {
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
  } box_t;

  function automatic logic signed [CALC_W-1:0] ext_pos(input logic signed [POS_W-1:0] p);
    return CALC_W'(p);
  endfunction

  function automatic logic signed [CALC_W-1:0] ext_vel(input logic signed [VEL_W-1:0] v);
    return CALC_W'(v);
  endfunction

  function automatic logic signed [CALC_W-1:0] ext_half(input logic [SIZE_W-2:0] h);
    return $signed({{(CALC_W - SIZE_W + 1){1'b0}}, h});
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [CALC_W-1:0] v);
    logic signed [CALC_W-1:0] c;
    c = v;
    if (v < POS_LO) c = POS_LO;
    if (v > POS_HI) c = POS_HI;
    return c[POS_W-1:0];
  endfunction

  function automatic logic signed [NVEL_W-1:0] sat_vel(input logic signed [CALC_W-1:0] v);
    logic signed [CALC_W-1:0] c;
    c = v;
    if (v < NVEL_LO) c = NVEL_LO;
    if (v > NVEL_HI) c = NVEL_HI;
    return c[NVEL_W-1:0];
  endfunction

endpackage

// File: design/swept_box_collision_mover_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_box_collision_mover_top
// Static box table in one memory, swept along each axis to move a body.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Clear and append
// requests keep busy low and return their result on done in the next cycle.
// A move walks the box table one entry per cycle through its single read
// port: a move runs one horizontal and one vertical sweep over the stored
// boxes, with control states around them; an axis with zero velocity
// skips its sweep, and an actor whose upward sweep turns its movement
// downward runs one more sweep. Results appear on the output ports for the
// single cycle in which done is high; the receiver cannot stall them.
module swept_box_collision_mover_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [sbcm_pkg::KIND_W-1:0]            kind,
  input  logic signed [sbcm_pkg::POS_W-1:0]      pos_x,
  input  logic signed [sbcm_pkg::POS_W-1:0]      pos_y,
  input  logic [sbcm_pkg::SIZE_W-1:0]            box_width,
  input  logic [sbcm_pkg::SIZE_W-1:0]            box_height,
  input  logic signed [sbcm_pkg::VEL_W-1:0]      vel_x,
  input  logic signed [sbcm_pkg::VEL_W-1:0]      vel_y,
  output logic                                   done,
  output logic signed [sbcm_pkg::POS_W-1:0]      new_x,
  output logic signed [sbcm_pkg::POS_W-1:0]      new_y,
  output logic signed [sbcm_pkg::NVEL_W-1:0]     new_vel_x,
  output logic signed [sbcm_pkg::NVEL_W-1:0]     new_vel_y,
  output logic                                   hit,
  output logic                                   table_full
);

`include "assert_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_VERT, ST_FINISH} st_t;
  typedef enum logic [1:0] {DIR_RIGHT, DIR_LEFT, DIR_UP, DIR_DOWN} dir_t;

  st_t  state;
  dir_t dir;

  sbcm_pkg::box_t mem [sbcm_pkg::MAX_STATIC];
  sbcm_pkg::box_t rd_data;

  logic [sbcm_pkg::CNT_W-1:0] static_count;
  logic [sbcm_pkg::CNT_W-1:0] rd_addr;
  logic                       s1_valid;
  logic                       s2_valid;

  logic signed [sbcm_pkg::CALC_W-1:0] x, y, vreq, pm, nvx, nvy;
  logic [sbcm_pkg::SIZE_W-2:0]        hw, hh;
  logic signed [sbcm_pkg::VEL_W-1:0]  vy_req;
  logic                               proj;
  logic                               hit_acc;

  logic signed [sbcm_pkg::CALC_W-1:0] ls, rs, ts, ds;
  logic signed [sbcm_pkg::CALC_W-1:0] l_d, r_d, t_d, d_d, contact, x_mv, y_mv;
  logic                               take;
  logic                               sweep_end;
  logic                               wr_en;

  assign busy      = (state != ST_IDLE);
  assign sweep_end = (rd_addr == static_count) && !s1_valid && !s2_valid;
  assign wr_en     = (state == ST_IDLE) && start && (kind == sbcm_pkg::KIND_APPEND) &&
                     (static_count < sbcm_pkg::MAX_COUNT);
  assign x_mv      = x + pm;
  assign y_mv      = y + pm;

  // Box table: written on append, read one entry a cycle during a sweep.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[static_count[sbcm_pkg::IDX_W-1:0]] <= '{cx: pos_x, cy: pos_y,
                                                  w: box_width, h: box_height};
    end
    rd_data <= mem[rd_addr[sbcm_pkg::IDX_W-1:0]];
  end

  // Edges of the stored box, one stage after the read.
  always_ff @(posedge clk) begin
    ls <= sbcm_pkg::ext_pos(rd_data.cx) - sbcm_pkg::ext_half(rd_data.w[sbcm_pkg::SIZE_W-1:1]);
    rs <= sbcm_pkg::ext_pos(rd_data.cx) + sbcm_pkg::ext_half(rd_data.w[sbcm_pkg::SIZE_W-1:1]);
    ts <= sbcm_pkg::ext_pos(rd_data.cy) - sbcm_pkg::ext_half(rd_data.h[sbcm_pkg::SIZE_W-1:1]);
    ds <= sbcm_pkg::ext_pos(rd_data.cy) + sbcm_pkg::ext_half(rd_data.h[sbcm_pkg::SIZE_W-1:1]);
  end

  always_comb begin
    l_d     = x - sbcm_pkg::ext_half(hw);
    r_d     = x + sbcm_pkg::ext_half(hw);
    t_d     = y - sbcm_pkg::ext_half(hh);
    d_d     = y + sbcm_pkg::ext_half(hh);
    contact = '0;
    take    = 1'b0;
    unique case (dir)
      DIR_RIGHT: begin
        contact = ls - r_d;
        take = (r_d + vreq >= ls) && (r_d <= ls) && (ts < d_d) && (ds > t_d) &&
               (pm >= contact);
      end
      DIR_LEFT: begin
        contact = rs - l_d;
        take = (l_d + vreq <= rs) && (l_d >= rs) && (ts < d_d) && (ds > t_d) &&
               (pm <= contact);
      end
      DIR_UP: begin
        contact = ds - t_d;
        take = (t_d + vreq <= ds) && (d_d > ts) && (l_d < rs) && (r_d > ls) &&
               (pm <= contact);
      end
      DIR_DOWN: begin
        contact = ts - d_d;
        take = (d_d + vreq >= ts) && (t_d < ds) && (l_d < rs) && (r_d > ls) &&
               (pm >= contact);
      end
      default: begin
        contact = '0;
        take    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      dir          <= DIR_RIGHT;
      static_count <= '0;
      rd_addr      <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      done         <= 1'b0;
    end else begin
      done     <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= s1_valid;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            proj    <= (kind == sbcm_pkg::KIND_PROJ);
            hit_acc <= 1'b0;
            x       <= sbcm_pkg::ext_pos(pos_x);
            y       <= sbcm_pkg::ext_pos(pos_y);
            hw      <= box_width[sbcm_pkg::SIZE_W-1:1];
            hh      <= box_height[sbcm_pkg::SIZE_W-1:1];
            vy_req  <= vel_y;
            rd_addr <= '0;
            unique case (kind) inside
              sbcm_pkg::KIND_CLEAR, sbcm_pkg::KIND_APPEND: begin
                if (kind == sbcm_pkg::KIND_CLEAR) begin
                  static_count <= '0;
                end else if (wr_en) begin
                  static_count <= static_count + sbcm_pkg::CNT_W'(1);
                end
                new_x      <= '0;
                new_y      <= '0;
                new_vel_x  <= '0;
                new_vel_y  <= '0;
                hit        <= 1'b0;
                table_full <= (kind == sbcm_pkg::KIND_APPEND) && !wr_en;
                done       <= 1'b1;
              end
              sbcm_pkg::KIND_ACTOR, sbcm_pkg::KIND_PROJ: begin
                vreq <= sbcm_pkg::ext_vel(vel_x);
                pm   <= sbcm_pkg::ext_vel(vel_x);
                if (!vel_x[sbcm_pkg::VEL_W-1] && (vel_x != '0)) begin
                  dir   <= DIR_RIGHT;
                  state <= ST_SWEEP;
                end else if (vel_x[sbcm_pkg::VEL_W-1]) begin
                  dir   <= DIR_LEFT;
                  state <= ST_SWEEP;
                end else begin
                  nvx   <= '0;
                  state <= ST_VERT;
                end
              end
              default: state <= ST_IDLE;
            endcase
          end
        end

        ST_SWEEP: begin
          if (rd_addr < static_count) begin
            rd_addr  <= rd_addr + sbcm_pkg::CNT_W'(1);
            s1_valid <= 1'b1;
          end
          if (s2_valid && take) begin
            if (proj) begin
              hit_acc <= 1'b1;
            end else begin
              pm <= contact;
            end
          end
          if (sweep_end) begin
            rd_addr <= '0;
            unique case (dir)
              DIR_RIGHT: begin
                x <= x_mv;
                // A right sweep ending negative is followed by a left sweep.
                if (pm[sbcm_pkg::CALC_W-1]) begin
                  dir  <= DIR_LEFT;
                  vreq <= pm;
                end else begin
                  nvx   <= pm;
                  state <= ST_VERT;
                end
              end
              DIR_LEFT: begin
                x     <= x_mv;
                nvx   <= pm;
                state <= ST_VERT;
              end
              DIR_UP: begin
                y <= y_mv;
                // An overlapping box can flip the movement downward.
                if (!pm[sbcm_pkg::CALC_W-1] && (pm != '0)) begin
                  dir  <= DIR_DOWN;
                  vreq <= pm;
                end else begin
                  nvy   <= pm;
                  state <= ST_FINISH;
                end
              end
              DIR_DOWN: begin
                y     <= y_mv;
                nvy   <= pm;
                state <= ST_FINISH;
              end
              default: state <= ST_FINISH;
            endcase
          end
        end

        ST_VERT: begin
          vreq    <= sbcm_pkg::ext_vel(vy_req);
          pm      <= sbcm_pkg::ext_vel(vy_req);
          rd_addr <= '0;
          if (vy_req[sbcm_pkg::VEL_W-1]) begin
            dir   <= DIR_UP;
            state <= ST_SWEEP;
          end else if (vy_req != '0) begin
            dir   <= DIR_DOWN;
            state <= ST_SWEEP;
          end else begin
            nvy   <= '0;
            state <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          new_x      <= sbcm_pkg::sat_pos(x);
          new_y      <= sbcm_pkg::sat_pos(y);
          new_vel_x  <= sbcm_pkg::sat_vel(nvx);
          new_vel_y  <= sbcm_pkg::sat_vel(nvy);
          hit        <= hit_acc;
          table_full <= 1'b0;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  `SBCM_ASSERT_IMP(a_done_source, done,
                   $past(state == ST_FINISH) || $past(start && !busy),
                   "result without a request or a finished move")
  `SBCM_ASSERT_IMP(a_read_in_sweep, s1_valid, $past(state == ST_SWEEP),
                   "table read outside a sweep")
  `SBCM_ASSERT_IMP(a_hit_proj, done && hit, proj, "hit raised for a non-projectile request")
  `SBCM_ASSERT(a_count_max, static_count <= sbcm_pkg::MAX_COUNT, "box count beyond table depth")

endmodule

// File: tb/swept_box_collision_mover_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_box_collision_mover_top_tb
// Drives clear, append and move requests into the swept box mover and checks
// every result against a scoreboard that keeps its own copy of the box table
// and repeats the horizontal and vertical sweeps for each accepted move.
// ----------------------------------------------------------------------------
module swept_box_collision_mover_top_tb;
  import sbcm_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int RESET_CYCLES    = 5;
  localparam int TARGET_REQUESTS = 1950;
  localparam int PHASE_LEN       = 250;
  localparam int MAX_GAP         = 40;
  // Longest move: three sweeps over a full table plus control.
  localparam int DRAIN_CYCLES    = 256;
  localparam int STALL_LIMIT     = 4000;
  localparam int IDLE_PCT [4]    = '{0, 79, 0, 18};

  typedef enum int {SWEEP_RIGHT, SWEEP_LEFT, SWEEP_UP, SWEEP_DOWN} sweep_dir_t;

  typedef struct {
    logic [KIND_W-1:0]       kind;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } move_request_t;

  typedef struct {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [NVEL_W-1:0] vx;
    logic signed [NVEL_W-1:0] vy;
    logic                     hit;
    logic                     full;
  } move_result_t;

  class collision_scoreboard;
    int           box_cx [MAX_STATIC];
    int           box_cy [MAX_STATIC];
    int           box_w  [MAX_STATIC];
    int           box_h  [MAX_STATIC];
    int           box_count;
    int           mismatches;
    move_result_t expected_results [$];

    function new();
      box_count  = 0;
      mismatches = 0;
    endfunction

    static function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Return the movement allowed along one direction; projectiles only flag.
    function int sweep_axis(sweep_dir_t dir, bit proj, int x, int y, int hw, int hh,
                            int v, inout bit struck);
      int  held;
      int  lm, rm, tm, bm;
      int  sw, sh, ls, rs, ts, bs, contact;
      bit  take;
      held = v;
      lm = x - hw;
      rm = x + hw;
      tm = y - hh;
      bm = y + hh;
      for (int i = 0; i < box_count; i++) begin
        sw = box_w[i] / 2;
        sh = box_h[i] / 2;
        ls = box_cx[i] - sw;
        rs = box_cx[i] + sw;
        ts = box_cy[i] - sh;
        bs = box_cy[i] + sh;
        case (dir)
          SWEEP_RIGHT: begin
            contact = ls - rm;
            take = (rm + v >= ls) && (rm <= ls) && (ts < bm) && (bs > tm) &&
                   (held >= contact);
          end
          SWEEP_LEFT: begin
            contact = rs - lm;
            take = (lm + v <= rs) && (lm >= rs) && (ts < bm) && (bs > tm) &&
                   (held <= contact);
          end
          SWEEP_UP: begin
            contact = bs - tm;
            take = (tm + v <= bs) && (bm > ts) && (lm < rs) && (rm > ls) &&
                   (held <= contact);
          end
          default: begin
            contact = ts - bm;
            take = (bm + v >= ts) && (tm < bs) && (lm < rs) && (rm > ls) &&
                   (held >= contact);
          end
        endcase
        if (take) begin
          if (proj) struck = 1'b1;
          else held = contact;
        end
      end
      return held;
    endfunction

    function void note_request(move_request_t r);
      move_result_t e;
      bit           proj;
      bit           struck;
      int           hw, hh, x, y, v, nvx;
      e.x    = '0;
      e.y    = '0;
      e.vx   = '0;
      e.vy   = '0;
      e.hit  = 1'b0;
      e.full = 1'b0;
      case (r.kind)
        KIND_CLEAR: box_count = 0;
        KIND_APPEND: begin
          if (box_count < MAX_STATIC) begin
            box_cx[box_count] = r.px;
            box_cy[box_count] = r.py;
            box_w[box_count]  = r.w;
            box_h[box_count]  = r.h;
            box_count++;
          end else begin
            e.full = 1'b1;
          end
        end
        default: begin
          proj   = (r.kind == KIND_PROJ);
          struck = 1'b0;
          hw     = int'(r.w) / 2;
          hh     = int'(r.h) / 2;
          x      = r.px;
          y      = r.py;
          v      = r.vx;
          if (v > 0) begin
            v = sweep_axis(SWEEP_RIGHT, proj, x, y, hw, hh, v, struck);
            x += v;
          end
          if (v < 0) begin
            v = sweep_axis(SWEEP_LEFT, proj, x, y, hw, hh, v, struck);
            x += v;
          end
          nvx = v;
          v   = r.vy;
          if (v < 0) begin
            v = sweep_axis(SWEEP_UP, proj, x, y, hw, hh, v, struck);
            y += v;
          end
          // An overlapping box can flip an actor downward: sweep again.
          if (v > 0) begin
            v = sweep_axis(SWEEP_DOWN, proj, x, y, hw, hh, v, struck);
            y += v;
          end
          e.x   = POS_W'(clamp(x, -32768, 32767));
          e.y   = POS_W'(clamp(y, -32768, 32767));
          e.vx  = NVEL_W'(clamp(nvx, -8191, 8191));
          e.vy  = NVEL_W'(clamp(v, -8191, 8191));
          e.hit = struck;
        end
      endcase
      expected_results.insert(expected_results.size(), e);
    endfunction

    function void check_result(move_result_t got);
      move_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request waiting");
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.x !== want.x) begin
        $error("new_x: expected %0d, actual %0d", want.x, got.x);
        mismatches++;
      end
      if (got.y !== want.y) begin
        $error("new_y: expected %0d, actual %0d", want.y, got.y);
        mismatches++;
      end
      if (got.vx !== want.vx) begin
        $error("new_vel_x: expected %0d, actual %0d", want.vx, got.vx);
        mismatches++;
      end
      if (got.vy !== want.vy) begin
        $error("new_vel_y: expected %0d, actual %0d", want.vy, got.vy);
        mismatches++;
      end
      if (got.hit !== want.hit) begin
        $error("hit: expected %0b, actual %0b", want.hit, got.hit);
        mismatches++;
      end
      if (got.full !== want.full) begin
        $error("table_full: expected %0b, actual %0b", want.full, got.full);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [KIND_W-1:0]        kind;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [SIZE_W-1:0]        box_width;
  logic [SIZE_W-1:0]        box_height;
  logic signed [VEL_W-1:0]  vel_x;
  logic signed [VEL_W-1:0]  vel_y;
  logic                     done;
  logic signed [POS_W-1:0]  new_x;
  logic signed [POS_W-1:0]  new_y;
  logic signed [NVEL_W-1:0] new_vel_x;
  logic signed [NVEL_W-1:0] new_vel_y;
  logic                     hit;
  logic                     table_full;

  collision_scoreboard sb;
  int                  sent_requests;
  int                  stall_cycles;

  swept_box_collision_mover_top u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .box_width  (box_width),
    .box_height (box_height),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .done       (done),
    .new_x      (new_x),
    .new_y      (new_y),
    .new_vel_x  (new_vel_x),
    .new_vel_y  (new_vel_y),
    .hit        (hit),
    .table_full (table_full)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    move_result_t got;
    if (!rst && done) begin
      got.x    = new_x;
      got.y    = new_y;
      got.vx   = new_vel_x;
      got.vy   = new_vel_y;
      got.hit  = hit;
      got.full = table_full;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Enter and leave at a falling edge; hold start across back-to-back requests.
  task automatic issue(logic [KIND_W-1:0] k, int px, int py, int w, int h, int vx, int vy);
    move_request_t r;
    int            gap;
    int            pct;
    r.kind = k;
    r.px   = POS_W'(px);
    r.py   = POS_W'(py);
    r.w    = SIZE_W'(w);
    r.h    = SIZE_W'(h);
    r.vx   = VEL_W'(vx);
    r.vy   = VEL_W'(vy);
    pct    = IDLE_PCT[(sent_requests / PHASE_LEN) % 4];
    gap    = 0;
    while (gap < MAX_GAP && $urandom_range(99) < pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind       <= r.kind;
    pos_x      <= r.px;
    pos_y      <= r.py;
    box_width  <= r.w;
    box_height <= r.h;
    vel_x      <= r.vx;
    vel_y      <= r.vy;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    sent_requests++;
    @(negedge clk);
  endtask

  function automatic int around(int c, int span);
    return c + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int rand_vel();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 0;
    if (pick < 70) return around(0, 150);
    return int'($urandom_range(0, 2047)) - 1024;
  endfunction

  function automatic int rand_size();
    if ($urandom_range(99) < 5) return $urandom_range(0, 4095);
    return $urandom_range(0, 200);
  endfunction

  initial begin
    int cx, cy, nbox, nmove;
    sb            = new();
    sent_requests = 0;
    rst           = 1'b1;
    start         = 1'b0;
    kind          = KIND_CLEAR;
    pos_x         = '0;
    pos_y         = '0;
    box_width     = '0;
    box_height    = '0;
    vel_x         = '0;
    vel_y         = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table with saturation, then one box hit from every side.
    issue(KIND_CLEAR, 0, 0, 0, 0, 0, 0);
    issue(KIND_ACTOR, 32767, -32768, 4095, 4095, 1023, -1024);
    issue(KIND_PROJ, -32768, 32767, 0, 0, -1024, 1023);
    issue(KIND_APPEND, 0, 0, 100, 100, 0, 0);
    issue(KIND_APPEND, 300, 0, 41, 4095, 0, 0);
    issue(KIND_ACTOR, -100, 0, 20, 20, 100, 0);
    issue(KIND_ACTOR, 100, 0, 20, 20, -100, 0);
    issue(KIND_ACTOR, 0, 100, 20, 20, 0, -100);
    issue(KIND_ACTOR, 0, -100, 20, 20, 0, 100);
    issue(KIND_ACTOR, 0, 10, 20, 20, 0, -5);
    issue(KIND_PROJ, -100, 0, 20, 20, 100, 0);
    issue(KIND_PROJ, 0, -100, 20, 20, 0, 100);
    issue(KIND_PROJ, -100, 500, 20, 20, 100, 0);
    issue(KIND_ACTOR, 5, 5, 20, 20, 0, 0);
    issue(KIND_ACTOR, -100, -100, 20, 20, 200, 200);
    issue(KIND_ACTOR, -3000, 0, 4095, 1, 1023, 0);
    issue(KIND_ACTOR, -60, 0, 20, 20, 1, 0);
    issue(KIND_ACTOR, 200, 0, 21, 21, -1024, 0);
    issue(KIND_APPEND, 32767, -32768, 4095, 0, -1, -1);
    issue(KIND_ACTOR, 32000, -32000, 3, 3, 1023, -1024);
    issue(KIND_CLEAR, -1, -1, 4095, 4095, -1, -1);

    // Random scenes: a local cluster of boxes, then bodies moved through it.
    while (sent_requests < TARGET_REQUESTS) begin
      if ($urandom_range(99) < 15) begin
        cx = $urandom_range(0, 1) ? 32600 : -32600;
        cy = $urandom_range(0, 1) ? 32600 : -32600;
      end else begin
        cx = around(0, 30000);
        cy = around(0, 30000);
      end
      if ($urandom_range(99) < 85)
        issue(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      nbox = ($urandom_range(99) < 25) ? $urandom_range(55, 70) : $urandom_range(0, 12);
      repeat (nbox) begin
        if ($urandom_range(99) < 10)
          issue(KIND_APPEND, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
          issue(KIND_APPEND, around(cx, 200), around(cy, 200), rand_size(), rand_size(),
                $urandom, $urandom);
      end
      nmove = $urandom_range(3, 12);
      repeat (nmove) begin
        if ($urandom_range(99) < 12)
          issue(KIND_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
        else
          issue(($urandom_range(99) < 65) ? KIND_ACTOR : KIND_PROJ, around(cx, 300),
                around(cy, 300), $urandom_range(0, 100), $urandom_range(0, 100),
                rand_vel(), rand_vel());
      end
    end
    start <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
